[rtl/yuv_rgb_color_converter_defines.svh]
// assertion helpers for the color converter
`ifndef YUV_RGB_COLOR_CONVERTER_DEFINES_SVH
`define YUV_RGB_COLOR_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define YRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("yrc assertion failed");

// next-cycle implication, disabled in reset
`define YRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("yrc assertion failed");

`endif

[rtl/yrc_pkg.sv]
package yrc_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COEF_W    = 17;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [1:0] {
        LANE_A = 2'd0,
        LANE_B = 2'd1,
        LANE_C = 2'd2
    } t_lane;

    typedef enum logic {
        DIR_YUV2RGB = 1'b0,
        DIR_RGB2YUV = 1'b1
    } t_dir;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    localparam t_coef K_ONE  = 17'sd16384;
    localparam t_coef K_ZERO = 17'sd0;
    localparam t_coef K_RV   = 17'sd22987;
    localparam t_coef K_GU   = 17'sd5620;
    localparam t_coef K_GV   = 17'sd11698;
    localparam t_coef K_BU   = 17'sd29000;
    localparam t_coef K_YR   = 17'sd4899;
    localparam t_coef K_YG   = 17'sd9617;
    localparam t_coef K_YB   = 17'sd1868;
    localparam t_coef K_UR   = 17'sd2769;
    localparam t_coef K_UG   = 17'sd5423;
    localparam t_coef K_HALF = 17'sd8192;
    localparam t_coef K_VG   = 17'sd6865;
    localparam t_coef K_VB   = 17'sd1327;

    // coefficient for one output lane and one input tap
    function automatic t_coef coef(input t_dir dir, input t_lane lane, input logic [1:0] tap);
        t_coef c;
        c = K_ZERO;
        if (dir == DIR_YUV2RGB) begin
            unique case (lane)
                LANE_A: begin
                    case (tap)
                        2'd0:    c = K_ONE;
                        2'd1:    c = K_ZERO;
                        default: c = K_RV;
                    endcase
                end
                LANE_B: begin
                    case (tap)
                        2'd0:    c = K_ONE;
                        2'd1:    c = -K_GU;
                        default: c = -K_GV;
                    endcase
                end
                default: begin
                    case (tap)
                        2'd0:    c = K_ONE;
                        2'd1:    c = K_BU;
                        default: c = K_ZERO;
                    endcase
                end
            endcase
        end else begin
            unique case (lane)
                LANE_A: begin
                    case (tap)
                        2'd0:    c = K_YR;
                        2'd1:    c = K_YG;
                        default: c = K_YB;
                    endcase
                end
                LANE_B: begin
                    case (tap)
                        2'd0:    c = -K_UR;
                        2'd1:    c = -K_UG;
                        default: c = K_HALF;
                    endcase
                end
                default: begin
                    case (tap)
                        2'd0:    c = K_HALF;
                        2'd1:    c = -K_VG;
                        default: c = -K_VB;
                    endcase
                end
            endcase
        end
        return c;
    endfunction

endpackage

[rtl/yrc_lane.sv]
module yrc_lane #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  yrc_pkg::t_lane                i_lane,
    input  yrc_pkg::t_stage_en            i_en,
    input  yrc_pkg::t_dir                 i_dir,
    input  logic signed [SAMPLE_BITS:0]   i_x0,
    input  logic signed [SAMPLE_BITS:0]   i_x1,
    input  logic signed [SAMPLE_BITS:0]   i_x2,
    output logic [SAMPLE_BITS-1:0]        o_res
);
    import yrc_pkg::*;

    localparam int PW = SAMPLE_BITS + 1 + COEF_W;
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] BIAS_HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] BIAS_OFFS =
        {{(SW-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1 + FRAC_BITS);
    localparam logic signed [SW-1:0] RES_MAX =
        ({{(SW-1){1'b0}}, 1'b1} << SAMPLE_BITS) - {{(SW-1){1'b0}}, 1'b1};

    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic signed [PW-1:0] n_p0, n_p1, n_p2;
    t_dir                 r_dir1;
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [SW-1:0] bias;
    logic signed [SW-1:0] shifted;
    logic [SAMPLE_BITS-1:0] r_res, n_res;

    // multiply stage
    always_comb begin
        n_p0 = PW'(coef(i_dir, i_lane, 2'd0)) * PW'(i_x0);
        n_p1 = PW'(coef(i_dir, i_lane, 2'd1)) * PW'(i_x1);
        n_p2 = PW'(coef(i_dir, i_lane, 2'd2)) * PW'(i_x2);
    end

    // sum stage
    always_comb begin
        if (r_dir1 == DIR_YUV2RGB) begin
            bias = BIAS_HALF;
        end else if (i_lane == LANE_A) begin
            bias = '0;
        end else begin
            bias = BIAS_OFFS;
        end
        n_sum = SW'(r_p0) + SW'(r_p1) + SW'(r_p2) + bias;
    end

    // scale and clamp stage
    always_comb begin
        shifted = r_sum >>> FRAC_BITS;
        if (shifted < 0) begin
            n_res = '0;
        end else if (shifted > RES_MAX) begin
            n_res = RES_MAX[SAMPLE_BITS-1:0];
        end else begin
            n_res = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_dir1 <= i_dir;
        end
        if (i_en.s2) begin
            r_sum <= n_sum;
        end
        if (i_en.s3) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[rtl/yuv_rgb_color_converter.sv]
// yuv_rgb_color_converter: full-range BT.601 pixel converter, YUV to RGB or RGB to YUV.
// Input channel: i_valid / o_ready with i_comp_a, i_comp_b, i_comp_c (Y,U,V or R,G,B).
// Output channel: o_valid / i_ready with o_out_a, o_out_b, o_out_c (R,G,B or Y,U,V).
// A request moves on a rising edge where valid and ready are both high.
// i_dir_we / i_dir_data write the direction bit (0: YUV in, 1: RGB in); write
// it only while no request is in flight.
// Requests pass through the operand, multiply, sum and scale/clamp register stages
// to o_valid. Throughput: one pixel per cycle while i_ready is high, set by the
// four-stage multiply-add pipeline with one multiplier per coefficient.
// Each stage holds its own valid bit; a stage loads when it is empty or when
// the stage after it moves, so bubbles close up while the receiver stalls.
// With i_ready low and all four stages full, o_ready drops; no request is
// dropped or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets direction 0.
module yuv_rgb_color_converter #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_dir_we,
    input  logic                   i_dir_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_comp_a,
    input  logic [SAMPLE_BITS-1:0] i_comp_b,
    input  logic [SAMPLE_BITS-1:0] i_comp_c,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_out_a,
    output logic [SAMPLE_BITS-1:0] o_out_b,
    output logic [SAMPLE_BITS-1:0] o_out_c
);
    import yrc_pkg::*;
    `include "yuv_rgb_color_converter_defines.svh"

    localparam logic signed [SAMPLE_BITS:0] CHROMA_OFFS =
        {2'b01, {(SAMPLE_BITS-1){1'b0}}};

    t_dir r_dir, r_dir0;
    logic r_v0, r_v1, r_v2, r_v3;
    logic rdy0, rdy1, rdy2, rdy3;
    logic signed [SAMPLE_BITS:0] r_x0, r_x1, r_x2;
    logic signed [SAMPLE_BITS:0] n_x0, n_x1, n_x2;
    t_stage_en en;
    logic [2:0] occ;

    assign rdy3 = !r_v3 || i_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;
    assign o_ready = rdy0;
    assign en = '{s1: rdy1, s2: rdy2, s3: rdy3};

    always_comb begin
        n_x0 = $signed({1'b0, i_comp_a});
        n_x1 = $signed({1'b0, i_comp_b});
        n_x2 = $signed({1'b0, i_comp_c});
        if (r_dir == DIR_YUV2RGB) begin
            n_x1 = $signed({1'b0, i_comp_b}) - CHROMA_OFFS;
            n_x2 = $signed({1'b0, i_comp_c}) - CHROMA_OFFS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_YUV2RGB;
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            if (i_dir_we) begin
                r_dir <= t_dir'(i_dir_data);
            end
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_x0   <= n_x0;
            r_x1   <= n_x1;
            r_x2   <= n_x2;
            r_dir0 <= r_dir;
        end
    end

    yrc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_a (
        .i_clk (i_clk),
        .i_lane(LANE_A),
        .i_en  (en),
        .i_dir (r_dir0),
        .i_x0  (r_x0),
        .i_x1  (r_x1),
        .i_x2  (r_x2),
        .o_res (o_out_a)
    );

    yrc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
        .i_clk (i_clk),
        .i_lane(LANE_B),
        .i_en  (en),
        .i_dir (r_dir0),
        .i_x0  (r_x0),
        .i_x1  (r_x1),
        .i_x2  (r_x2),
        .o_res (o_out_b)
    );

    yrc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_c (
        .i_clk (i_clk),
        .i_lane(LANE_C),
        .i_en  (en),
        .i_dir (r_dir0),
        .i_x0  (r_x0),
        .i_x1  (r_x1),
        .i_x2  (r_x2),
        .o_res (o_out_c)
    );

    assign o_valid = r_v3;

    assign occ = 3'($countones({r_v0, r_v1, r_v2, r_v3}));

    // occupancy changes only by requests in and out
    `YRC_ASSERT_NXT(a_occupancy, i_clk, i_rst_n, 1'b1, occ == $past(occ) + $past(i_valid && o_ready) - $past(o_valid && i_ready))
    `YRC_ASSERT_NXT(a_in_lands, i_clk, i_rst_n, i_valid && o_ready, r_v0)
    `YRC_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_v3 && r_v2 && !i_ready, r_v3 && r_v2)

endmodule
